FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define NCV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ncv_pkg.sv
// shared types and constants of the normalized convolution block
`default_nettype none
package ncv_pkg;

  localparam int CNT_W     = 10;
  localparam int EXT_W     = 13;
  localparam int VAL_W     = 21;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 11;
  localparam int KS_CFG_W  = 3;
  localparam int KROWS     = 5;
  localparam int KIDX_W    = 3;
  localparam int COEF_W    = 8;
  localparam int MAX_HEIGHT = 1024;
  localparam int VALUE_MAX = 1048575;
  localparam int VALUE_MIN = -1048576;

  localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd1024;
  localparam logic [KS_CFG_W-1:0] KSIZE_RST  = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KSIZE  = 3'd2,
    REG_KROW0  = 3'd3,
    REG_KROW1  = 3'd4,
    REG_KROW2  = 3'd5,
    REG_KROW3  = 3'd6,
    REG_KROW4  = 3'd7
  } ncv_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_MAC,
    S_ACC,
    S_DIVSET,
    S_DIV,
    S_OUT
  } ncv_state_t;

  typedef struct packed {
    logic in_stall;
    logic wr_en;
    logic rd_en;
    logic div_start;
    logic out_load;
  } ncv_ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/normalized_conv2d_valid.sv
// top level of the normalized 2-d convolution over the valid region
`default_nettype none
// Pixels arrive one request at a time in raster order and are written to a
// line store of MAX_KERNEL rows. For each position where the k x k window
// fits, the window is read back from the store one pixel per cycle and
// multiplied into an accumulator, then the sum is divided by the kernel sum
// by a one-bit-per-cycle divider. A pixel that makes no result is only
// written to the store. For one that makes a result, the single read port of
// the line store and the divider set the time it takes; the divider is
// skipped when the kernel sum is zero. The result sits in an output
// register, so the next pixel is taken while it waits; a further result
// waits for that register. A column index at or past MAX_WIDTH is brought
// back into range in S_WRAP before it is written.
module normalized_conv2d_valid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 5,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // pixel requests
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_pixel,
  // result requests
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [ncv_pkg::VAL_W-1:0]    out_value,
  output logic                                out_zero_sum,
  output logic [ncv_pkg::CNT_W-1:0]           out_row,
  output logic [ncv_pkg::CNT_W-1:0]           out_col,
  output logic                                out_last,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [ncv_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [ncv_pkg::CFG_W-1:0]      cfg_data
);

  import ncv_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int AW    = SW + CW;
  localparam int DEPTH = MAX_KERNEL << CW;
  localparam int TAPS  = $clog2(MAX_KERNEL * MAX_KERNEL);
  localparam int ACC_W = PIXEL_BITS + COEF_W + 1 + TAPS;
  localparam int KS_W  = COEF_W + TAPS;
  localparam int PR_W  = PIXEL_BITS + COEF_W + 1;
  localparam int QW    = ACC_W + 1;

  // configuration registers
  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;
  logic [KS_CFG_W-1:0] ksize_r;
  logic [CFG_W-1:0]    kern_r [KROWS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      ksize_r  <= KSIZE_RST;
      for (int i = 0; i < KROWS; i++) begin
        kern_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH:  width_r   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r  <= cfg_data[DIM_W-1:0];
        REG_KSIZE:  ksize_r   <= cfg_data[KS_CFG_W-1:0];
        REG_KROW0:  kern_r[0] <= cfg_data;
        REG_KROW1:  kern_r[1] <= cfg_data;
        REG_KROW2:  kern_r[2] <= cfg_data;
        REG_KROW3:  kern_r[3] <= cfg_data;
        REG_KROW4:  kern_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry: zero reads as one, large values saturate, an even kernel size drops to the odd one below
  logic [EXT_W-1:0]  eff_w, eff_h;
  logic [KIDX_W-1:0] eff_k;

  always_comb begin
    if (width_r == '0) eff_w = EXT_W'(1);
    else if (width_r > MAX_WIDTH) eff_w = EXT_W'(MAX_WIDTH);
    else eff_w = EXT_W'(width_r);
    if (height_r == '0) eff_h = EXT_W'(1);
    else if (height_r > MAX_HEIGHT) eff_h = EXT_W'(MAX_HEIGHT);
    else eff_h = EXT_W'(height_r);
    if (ksize_r > MAX_KERNEL) eff_k = KIDX_W'(MAX_KERNEL);
    else eff_k = KIDX_W'(ksize_r);
    if (eff_k == '0) eff_k = KIDX_W'(1);
    if (!eff_k[0]) eff_k = eff_k - 1'b1;
  end

  // state
  ncv_state_t state_r, state_nxt;
  ncv_ctl_t   ctl;

  logic [CNT_W-1:0]  row_r, col_r;
  logic [SW-1:0]     slot_r;
  logic [PIXEL_BITS-1:0] pix_r;
  logic [CNT_W-1:0]  wcol_r;
  logic              wrap_need;
  logic              produce;
  logic [EXT_W-1:0]  row_p1, col_p1;

  // window walk
  logic [KIDX_W-1:0] k_r, rr_r, cc_r;
  logic [SW-1:0]     rd_slot_r, start_slot;
  logic [CNT_W-1:0]  rd_col_r, c0_r, r0_r;
  logic              last_r;
  logic              walk_end;

  // accumulation
  logic                     rd_vld_r;
  logic [PIXEL_BITS-1:0]    rd_data;
  logic signed [COEF_W-1:0] coef_sel, coef_d_r;
  logic signed [PR_W-1:0]   prod;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [KS_W-1:0]   ks_r;
  logic                     neg_r;

  // divider
  logic             div_done;
  logic [ACC_W-1:0] div_quo;
  logic [ACC_W-1:0] num_abs;
  logic [KS_W-1:0]  den_abs;
  logic signed [QW-1:0]    q_signed;
  logic signed [VAL_W-1:0] q_sat;
  logic signed [VAL_W-1:0] res_value_r;
  logic                    res_zero_r;

  assign wrap_need = (wcol_r >= MAX_WIDTH);
  assign row_p1    = EXT_W'(row_r) + 1'b1;
  assign col_p1    = EXT_W'(col_r) + 1'b1;
  assign produce   = (row_p1 >= EXT_W'(eff_k)) && (col_p1 >= EXT_W'(eff_k))
                   && (EXT_W'(col_r) < eff_w) && (EXT_W'(row_r) < eff_h);
  assign walk_end  = (rr_r == k_r - 1'b1) && (cc_r == k_r - 1'b1);

  // first window row lies k-1 rows above the current one, modulo the store
  always_comb begin
    if (SW'(eff_k - 1'b1) <= slot_r) start_slot = slot_r - SW'(eff_k - 1'b1);
    else start_slot = SW'(MAX_KERNEL) + slot_r - SW'(eff_k - 1'b1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_WRAP;
      S_WRAP:   if (!wrap_need) state_nxt = produce ? S_MAC : S_IDLE;
      S_MAC:    if (walk_end) state_nxt = S_ACC;
      S_ACC:    state_nxt = S_DIVSET;
      S_DIVSET: state_nxt = (ks_r == '0) ? S_OUT : S_DIV;
      S_DIV:    if (div_done) state_nxt = S_OUT;
      S_OUT:    if (!out_valid || !out_stall) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE:   ctl.in_stall  = 1'b0;
      S_WRAP:   begin
        ctl.in_stall = 1'b1;
        ctl.wr_en    = !wrap_need;
      end
      S_MAC:    begin
        ctl.in_stall = 1'b1;
        ctl.rd_en    = 1'b1;
      end
      S_DIVSET: begin
        ctl.in_stall  = 1'b1;
        ctl.div_start = (ks_r != '0);
      end
      S_OUT:    begin
        ctl.in_stall = 1'b1;
        ctl.out_load = !out_valid || !out_stall;
      end
      default:  ctl.in_stall = 1'b1;
    endcase
  end

  assign in_stall = ctl.in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // raster position; slot_r tracks row_r modulo the store height
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (ctl.wr_en) begin
      if (col_p1 >= eff_w) begin
        col_r <= '0;
        if (row_p1 >= eff_h) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= row_p1[CNT_W-1:0];
          slot_r <= (slot_r == SW'(MAX_KERNEL - 1)) ? '0 : slot_r + 1'b1;
        end
      end else begin
        col_r <= col_p1[CNT_W-1:0];
      end
    end
  end

  // pixel capture and column wrap
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      pix_r  <= PIXEL_BITS'(in_pixel);
      wcol_r <= col_r;
    end else if (state_r == S_WRAP && wrap_need) begin
      wcol_r <= CNT_W'(wcol_r - CNT_W'(MAX_WIDTH));
    end
  end

  // window walk over the store
  always_ff @(posedge clk) begin
    if (ctl.wr_en && produce) begin
      k_r       <= eff_k;
      rr_r      <= '0;
      cc_r      <= '0;
      rd_slot_r <= start_slot;
      c0_r      <= CNT_W'(col_p1 - EXT_W'(eff_k));
      rd_col_r  <= CNT_W'(col_p1 - EXT_W'(eff_k));
      r0_r      <= CNT_W'(row_p1 - EXT_W'(eff_k));
      last_r    <= (row_p1 == eff_h) && (col_p1 == eff_w);
    end else if (ctl.rd_en) begin
      if (cc_r == k_r - 1'b1) begin
        cc_r      <= '0;
        rd_col_r  <= c0_r;
        rr_r      <= rr_r + 1'b1;
        rd_slot_r <= (rd_slot_r == SW'(MAX_KERNEL - 1)) ? '0 : rd_slot_r + 1'b1;
      end else begin
        cc_r     <= cc_r + 1'b1;
        rd_col_r <= rd_col_r + 1'b1;
      end
    end
  end

  // coefficients past the fifth row or column are zero
  always_comb begin
    coef_sel = '0;
    if (rr_r < KROWS && cc_r < KROWS) begin
      coef_sel = kern_r[rr_r][COEF_W*cc_r +: COEF_W];
    end
  end

  ncv_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr ({slot_r, CW'(wcol_r)}),
    .wr_data (pix_r),
    .rd_en   (ctl.rd_en),
    .rd_addr ({rd_slot_r, CW'(rd_col_r)}),
    .rd_data (rd_data)
  );

  assign prod = $signed({1'b0, rd_data}) * coef_d_r;

  // multiply-accumulate one tap behind the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    coef_d_r <= coef_sel;
    if (ctl.wr_en && produce) begin
      acc_r <= '0;
      ks_r  <= '0;
    end else if (rd_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod);
      ks_r  <= ks_r + KS_W'(coef_d_r);
    end
  end

  assign num_abs = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign den_abs = ks_r[KS_W-1] ? KS_W'(-ks_r) : KS_W'(ks_r);

  ncv_div #(
    .NUM_W (ACC_W),
    .DEN_W (KS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (num_abs),
    .den   (den_abs),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sign back on, then clamp to the result range
  always_comb begin
    q_signed = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    if (q_signed > VALUE_MAX) q_sat = VAL_W'(VALUE_MAX);
    else if (q_signed < VALUE_MIN) q_sat = VAL_W'(VALUE_MIN);
    else q_sat = VAL_W'(q_signed);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIVSET) begin
      neg_r       <= acc_r[ACC_W-1] ^ ks_r[KS_W-1];
      res_value_r <= '0;
      res_zero_r  <= (ks_r == '0);
    end else if (state_r == S_DIV && div_done) begin
      res_value_r <= q_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_value    <= res_value_r;
      out_zero_sum <= res_zero_r;
      out_row      <= r0_r;
      out_col      <= c0_r;
      out_last     <= last_r;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ncv_line_mem.sv
// line store: one write port, one read port, registered read data
`default_nettype none
module ncv_line_mem #(
  parameter int DEPTH = 5120,
  parameter int AW    = 13,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ncv_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module ncv_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    rem_nxt = rem_r;
    quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = DEN_W'(trial - {1'b0, den_r});
      quo_nxt[0] = 1'b1;
    end else begin
      rem_nxt = trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ncv_checker.sv
// port-level checks for the normalized convolution block, bound to the top
`default_nettype none
`include "assert_macros.svh"
module ncv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [20:0] out_value,
  input wire logic        out_zero_sum
);

  // a stalled result holds
  `NCV_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_value), "stalled result changed")

  // reset empties the output register
  `NCV_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // an accepted pixel keeps the block busy on the next cycle
  `NCV_ASSERT(a_busy_after, clk, rst_n, in_valid && !in_stall |=> in_stall, "pixel taken twice in a row")

  // a zero kernel sum gives a zero value
  `NCV_ASSERT(a_zero_val, clk, rst_n, out_valid && out_zero_sum |-> out_value == 21'd0, "zero sum with nonzero value")

endmodule

bind normalized_conv2d_valid ncv_checker u_ncv_checker (.*);
`default_nettype wire
